// ===== hw/rtl/khc_pkg.sv =====
`timescale 1ns / 1ps

package khc_pkg;

  localparam int unsigned KMER_CODE_W = 14;
  localparam int unsigned QDEPTH      = 2;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_MARKER   = 8'h3E;  // '>'
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS    = 8'h20;
  localparam logic [7:0] CH_A        = 8'h41;
  localparam logic [7:0] CH_C        = 8'h43;
  localparam logic [7:0] CH_G        = 8'h47;
  localparam logic [7:0] CH_T        = 8'h54;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_READ  = 2'd2
  } khc_kind_e;

  typedef struct packed {
    khc_kind_e kind;
    logic      stopped;
  } khc_cmd_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  char_byte;
    logic [13:0] read_code;
  } khc_in_t;

  typedef struct packed {
    logic [31:0] count_value;
    logic [13:0] kmer_code;
    logic        counted;
    logic        stopped;
  } khc_out_t;

  // {valid, base}
  function automatic logic [2:0] base_decode(logic [7:0] ch);
    logic [7:0] u;
    logic [2:0] r;
    u = ch;
    if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      u = ch - CASE_OFS;
    end
    unique case (u)
      CH_A:    r = {1'b1, BASE_A};
      CH_C:    r = {1'b1, BASE_C};
      CH_G:    r = {1'b1, BASE_G};
      CH_T:    r = {1'b1, BASE_T};
      default: r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/khc_front.sv =====
`timescale 1ns / 1ps

module khc_front #(
  parameter int unsigned MAX_K = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  khc_pkg::khc_in_t       in_data_i,
  input  logic [2:0]             kmer_length_i,
  input  logic                   q_ready_i,
  output logic                   push_o,
  output khc_pkg::khc_cmd_t      cmd_o,
  output logic [2*MAX_K-1:0]     code_o
);

  localparam int unsigned CW = 2 * MAX_K;
  localparam int unsigned RW = $clog2(MAX_K + 1);
  localparam int unsigned EW = (RW > 3) ? RW : 3;

  logic [CW-1:0] shift_q, shift_d;
  logic [RW-1:0] run_q, run_d;
  logic          stop_q, stop_d;
  logic [EW-1:0] eff_k;
  logic [EW-1:0] len_ext;
  logic [CW-1:0] kmask;
  logic [2:0]    dec;
  logic          printable;
  logic          fire;

  assign in_ready_o = q_ready_i;
  assign fire       = in_valid_i && q_ready_i;
  assign push_o     = fire;
  assign printable  = (in_data_i.char_byte >= khc_pkg::CH_PRINT_LO) &&
                      (in_data_i.char_byte <= khc_pkg::CH_PRINT_HI);
  assign dec        = khc_pkg::base_decode(in_data_i.char_byte);
  assign len_ext    = EW'(kmer_length_i);

  always_comb begin
    priority if (len_ext == '0) begin
      eff_k = EW'(1);
    end else if (len_ext > EW'(MAX_K)) begin
      eff_k = EW'(MAX_K);
    end else begin
      eff_k = len_ext;
    end
  end

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      kmask[i] = ((EW + 1)'(i) < {eff_k, 1'b0});
    end
  end

  always_comb begin
    shift_d      = shift_q;
    run_d        = run_q;
    stop_d       = stop_q;
    cmd_o.kind   = khc_pkg::KIND_NONE;
    code_o       = '0;
    if (in_data_i.op == khc_pkg::OP_READ) begin
      cmd_o.kind = khc_pkg::KIND_READ;
      code_o     = CW'(in_data_i.read_code);
    end else if (!stop_q && printable) begin
      if (in_data_i.char_byte == khc_pkg::CH_MARKER) begin
        stop_d = 1'b1;
      end else if (!dec[2]) begin
        run_d = '0;
      end else begin
        shift_d = CW'({shift_q, dec[1:0]});
        if (run_q < RW'(MAX_K)) begin
          run_d = run_q + RW'(1);
        end
        if (EW'(run_d) >= eff_k) begin
          cmd_o.kind = khc_pkg::KIND_COUNT;
          code_o     = shift_d & kmask;
        end
      end
    end
    cmd_o.stopped = stop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= '0;
      run_q   <= '0;
      stop_q  <= 1'b0;
    end else if (fire) begin
      shift_q <= shift_d;
      run_q   <= run_d;
      stop_q  <= stop_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stop_q |=> stop_q)
    else $error("stop flag cleared");

endmodule

// ===== hw/rtl/khc_fifo.sv =====
`timescale 1ns / 1ps

module khc_fifo #(
  parameter int unsigned WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             wready_o,
  input  logic             pop_i,
  output logic             rvalid_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PW = $clog2(khc_pkg::QDEPTH);
  localparam int unsigned NW = $clog2(khc_pkg::QDEPTH + 1);

  logic [WIDTH-1:0] ent_q [khc_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]    cnt_q;

  assign wready_o = (cnt_q != NW'(khc_pkg::QDEPTH));
  assign rvalid_o = (cnt_q != '0);
  assign rdata_o  = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PW'(1);
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + NW'(1);
        2'b01:   cnt_q <= cnt_q - NW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> wready_o)
    else $error("push into full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> rvalid_o)
    else $error("pop from empty queue");

endmodule

// ===== hw/rtl/khc_back.sv =====
`timescale 1ns / 1ps

module khc_back #(
  parameter int unsigned MAX_K = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  khc_pkg::khc_cmd_t    q_cmd_i,
  input  logic [2*MAX_K-1:0]   q_code_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output khc_pkg::khc_out_t    out_data_o,
  output logic                 clearing_o
);

  localparam int unsigned CW    = 2 * MAX_K;
  localparam int unsigned DEPTH = 1 << CW;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rd_q;

  logic              clr_q;
  logic [CW-1:0]     clr_addr_q;

  logic              b_vld_q;
  khc_pkg::khc_cmd_t b_cmd_q;
  logic [CW-1:0]     b_code_q;

  logic              wr_vld_q;
  logic [CW-1:0]     wr_addr_q;
  logic [31:0]       wr_data_q;

  logic              out_vld_q;
  khc_pkg::khc_out_t out_q, out_d;

  logic              b_go, b_take, pop;
  logic              fwd_hit;
  logic [31:0]       cur, inc;
  logic              we;
  logic [CW-1:0]     waddr;
  logic [31:0]       wdata;

  assign b_go    = b_vld_q && (!out_vld_q || out_ready_i);
  assign b_take  = !b_vld_q || b_go;
  assign pop     = q_valid_i && b_take && !clr_q;
  assign q_pop_o = pop;

  assign fwd_hit = wr_vld_q && (wr_addr_q == b_code_q);
  assign cur     = fwd_hit ? wr_data_q : rd_q;
  assign inc     = (cur == khc_pkg::CNT_MAX) ? cur : cur + 32'd1;

  assign we    = clr_q || (b_go && b_cmd_q.kind == khc_pkg::KIND_COUNT);
  assign waddr = clr_q ? clr_addr_q : b_code_q;
  assign wdata = clr_q ? 32'd0 : inc;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (pop) begin
      rd_q <= mem[q_code_i];
    end
  end

  always_comb begin
    out_d.stopped = b_cmd_q.stopped;
    unique case (b_cmd_q.kind)
      khc_pkg::KIND_COUNT: begin
        out_d.count_value = inc;
        out_d.kmer_code   = khc_pkg::KMER_CODE_W'(b_code_q);
        out_d.counted     = 1'b1;
      end
      khc_pkg::KIND_READ: begin
        out_d.count_value = cur;
        out_d.kmer_code   = khc_pkg::KMER_CODE_W'(b_code_q);
        out_d.counted     = 1'b0;
      end
      default: begin
        out_d.count_value = '0;
        out_d.kmer_code   = '0;
        out_d.counted     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      b_cmd_q  <= q_cmd_i;
      b_code_q <= q_code_i;
    end
    if (we) begin
      wr_addr_q <= waddr;
      wr_data_q <= wdata;
    end
    if (b_go) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      b_vld_q    <= 1'b0;
      wr_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + CW'(1);
        if (clr_addr_q == '1) clr_q <= 1'b0;
      end
      if (pop) begin
        b_vld_q <= 1'b1;
      end else if (b_go) begin
        b_vld_q <= 1'b0;
      end
      if (we) wr_vld_q <= 1'b1;
      if (b_go) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign clearing_o  = clr_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !b_vld_q && !out_vld_q)
    else $error("word in flight during table clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.counted |-> out_q.count_value != 32'd0)
    else $error("counted word with zero count");

endmodule

// ===== hw/rtl/kmer_histogram_counter_unit.sv =====
`timescale 1ns / 1ps
// Path: input accept, queue entry, table read, output register; output stalls hold words.
// Throughput: one word per cycle unless out_ready_i stalls; back-to-back same-code increments forward.
// Reset: async active low; after reset the count table is zeroed by a sweep over
// all 4**MAX_K entries (16384 at MAX_K = 7), with in_ready_o low until it ends.
// kmer_length resets to 7; config writes are taken during the sweep.
module kmer_histogram_counter_unit #(
  parameter int unsigned MAX_K = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  khc_pkg::khc_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output khc_pkg::khc_out_t out_data_o
);

  localparam int unsigned CW = 2 * MAX_K;
  localparam int unsigned QW = $bits(khc_pkg::khc_cmd_t) + CW;

  logic [2:0]        kmer_length_q;
  logic              clearing;
  logic              q_wready, front_ready;
  logic              push, pop, q_valid;
  khc_pkg::khc_cmd_t f_cmd, q_cmd;
  logic [CW-1:0]     f_code, q_code;
  logic [QW-1:0]     q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= 3'd7;
    end else if (cfg_we_i) begin
      kmer_length_q <= cfg_data_i;
    end
  end

  assign front_ready = q_wready && !clearing;

  khc_front #(
    .MAX_K(MAX_K)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .kmer_length_i(kmer_length_q),
    .q_ready_i    (front_ready),
    .push_o       (push),
    .cmd_o        (f_cmd),
    .code_o       (f_code)
  );

  khc_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_cmd, f_code}),
    .wready_o(q_wready),
    .pop_i   (pop),
    .rvalid_o(q_valid),
    .rdata_o (q_rdata)
  );

  assign q_cmd  = q_rdata[QW-1:CW];
  assign q_code = q_rdata[CW-1:0];

  khc_back #(
    .MAX_K(MAX_K)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (pop),
    .q_cmd_i    (q_cmd),
    .q_code_i   (q_code),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .clearing_o (clearing)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import khc_pkg::*;

  localparam int MAX_K          = KMER_CODE_W / 2;
  localparam int TABLE_DEPTH    = 1 << KMER_CODE_W;
  localparam int WATCHDOG_LIMIT = 50000;  // covers the table clear after reset
  localparam int DRAIN_CYCLES   = 8;
  localparam int CHUNK_WORDS    = 100;
  localparam int RECENT_DEPTH   = 16;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [2:0] cfg_data_i;
  logic       in_valid_i;
  logic       in_ready_o;
  khc_in_t    in_data_i;
  logic       out_valid_o;
  logic       out_ready_i;
  khc_out_t   out_data_o;

  kmer_histogram_counter_unit #(
    .MAX_K(MAX_K)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // histogram shadow
  logic [31:0] kmer_counts [TABLE_DEPTH];
  logic [13:0] base_history;
  logic [2:0]  valid_run;
  logic        record_stop;
  logic [2:0]  kmer_len;

  khc_out_t    expected_q [$];
  logic [13:0] recent_codes [$];
  int          error_count;
  int          words_sent;
  int          reads_sent;
  int          kmers_counted;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          idle_cycles;

  function automatic khc_out_t count_kmer(khc_in_t w);
    khc_out_t    r;
    logic [7:0]  ch;
    logic [1:0]  b;
    logic        is_base;
    logic [2:0]  k;
    logic [13:0] idx;
    r = '0;
    if (w.op == OP_READ) begin
      r.count_value = kmer_counts[w.read_code];
      r.kmer_code   = w.read_code;
    end else if (!record_stop && w.char_byte >= CH_PRINT_LO && w.char_byte <= CH_PRINT_HI) begin
      if (w.char_byte == CH_MARKER) begin
        record_stop = 1'b1;
      end else begin
        ch = w.char_byte;
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
          ch = ch - CASE_OFS;
        end
        is_base = 1'b1;
        b = BASE_A;
        case (ch)
          CH_A: b = BASE_A;
          CH_C: b = BASE_C;
          CH_G: b = BASE_G;
          CH_T: b = BASE_T;
          default: is_base = 1'b0;
        endcase
        if (!is_base) begin
          valid_run = '0;
        end else begin
          k = (kmer_len == 3'd0) ? 3'd1 : kmer_len;
          base_history = {base_history[11:0], b};
          if (valid_run < 3'(MAX_K)) begin
            valid_run = valid_run + 3'd1;
          end
          if (valid_run >= k) begin
            idx = base_history & ~(14'h3FFF << (2 * k));
            if (kmer_counts[idx] != CNT_MAX) begin
              kmer_counts[idx] = kmer_counts[idx] + 32'd1;
            end
            r.count_value = kmer_counts[idx];
            r.kmer_code   = idx;
            r.counted     = 1'b1;
          end
        end
      end
    end
    r.stopped = record_stop;
    return r;
  endfunction

  function automatic khc_in_t feed_word(logic [7:0] ch);
    khc_in_t w;
    w.op        = OP_FEED;
    w.char_byte = ch;
    w.read_code = 14'($urandom);
    return w;
  endfunction

  function automatic khc_in_t read_word(logic [13:0] code);
    khc_in_t w;
    w.op        = OP_READ;
    w.char_byte = 8'($urandom);
    w.read_code = code;
    return w;
  endfunction

  function automatic logic [7:0] random_base_char();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = CH_A;
      1: c = CH_C;
      2: c = CH_G;
      default: c = CH_T;
    endcase
    if ($urandom_range(1) == 1) begin
      c = c + CASE_OFS;
    end
    return c;
  endfunction

  // printable, not a base, not the record marker
  function automatic logic [7:0] random_break_char();
    logic [7:0] c;
    logic [7:0] u;
    do begin
      c = 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
      u = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_OFS : c;
    end while (c == CH_MARKER || u == CH_A || u == CH_C || u == CH_G || u == CH_T);
    return c;
  endfunction

  function automatic logic [7:0] random_silent_char();
    if ($urandom_range(1) == 1) begin
      return 8'($urandom_range(CH_PRINT_LO - 1));
    end
    return 8'($urandom_range(255, CH_PRINT_HI + 1));
  endfunction

  function automatic khc_in_t random_word();
    khc_in_t     w;
    int unsigned pick;
    w = feed_word(random_base_char());
    pick = $urandom_range(99);
    if (pick < 15) begin
      w = read_word(14'($urandom));
      if (recent_codes.size() != 0 && $urandom_range(1) == 1) begin
        w.read_code = recent_codes[$urandom_range(recent_codes.size() - 1)];
      end
    end else if (pick < 85) begin
      w.char_byte = random_base_char();
    end else if (pick < 93) begin
      w.char_byte = random_break_char();
    end else begin
      w.char_byte = random_silent_char();
    end
    return w;
  endfunction

  task automatic send_word(input khc_in_t w);
    khc_out_t exp_w;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    exp_w = count_kmer(w);
    expected_q.push_back(exp_w);
    words_sent++;
    if (w.op == OP_READ) begin
      reads_sent++;
    end
    if (exp_w.counted) begin
      kmers_counted++;
      recent_codes.push_back(exp_w.kmer_code);
      if (recent_codes.size() > RECENT_DEPTH) begin
        recent_codes.delete(0);
      end
    end
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(feed_word(s[i]));
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_kmer_length(input logic [2:0] k);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= k;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    kmer_len = k;
  endtask

  task automatic test_reset_contents();
    send_word(read_word(14'h0000));
    send_word(read_word(14'h3FFF));
    send_word(read_word(14'h1555));
  endtask

  task automatic test_full_length_windows();
    feed_text("ACGTacgT");
    send_word(feed_word(8'h00));
    send_word(feed_word(8'h20));
    send_word(feed_word(8'h7F));
    send_word(feed_word(8'hFF));
    feed_text("g");
    feed_text("n");
    send_word(read_word(recent_codes[0]));
  endtask

  task automatic test_length_change();
    feed_text("TTTT");
    drain_results();
    set_kmer_length(3'd3);
    feed_text("A");
    send_word(read_word(recent_codes[recent_codes.size() - 1]));
    drain_results();
    set_kmer_length(3'd0);
    feed_text("c");
  endtask

  task automatic test_random_stream(input int idle_pct, input int stall_pct, input int first);
    logic [2:0] k_plan [12] = '{3'd1, 3'd7, 3'd0, 3'd4, 3'd2, 3'd7,
                                3'd5, 3'd3, 3'd6, 3'd1, 3'd7, 3'd2};
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int c = first; c < first + 4; c++) begin
      drain_results();
      set_kmer_length(k_plan[c]);
      repeat (CHUNK_WORDS) send_word(random_word());
    end
  endtask

  task automatic test_record_stop();
    drain_results();
    set_kmer_length(3'd2);
    feed_text("AC>");
    feed_text("GTacgt>N");
    send_word(read_word(recent_codes[recent_codes.size() - 1]));
    repeat (20) send_word(random_word());
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    khc_out_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected word: count_value %0d kmer_code %0h",
               out_data_o.count_value, out_data_o.kmer_code);
        error_count++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_data_o.count_value !== exp_w.count_value) begin
          $error("count_value expected %0d got %0d", exp_w.count_value, out_data_o.count_value);
          error_count++;
        end
        if (out_data_o.kmer_code !== exp_w.kmer_code) begin
          $error("kmer_code expected %0h got %0h", exp_w.kmer_code, out_data_o.kmer_code);
          error_count++;
        end
        if (out_data_o.counted !== exp_w.counted) begin
          $error("counted expected %0b got %0b", exp_w.counted, out_data_o.counted);
          error_count++;
        end
        if (out_data_o.stopped !== exp_w.stopped) begin
          $error("stopped expected %0b got %0b", exp_w.stopped, out_data_o.stopped);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d words pending",
                 idle_cycles, expected_q.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    out_ready_i <= 1'b0;
    idle_cycles = 0;
    error_count = 0;
    words_sent = 0;
    reads_sent = 0;
    kmers_counted = 0;
    send_idle_pct = 10;
    recv_stall_pct = 75;
    foreach (kmer_counts[i]) kmer_counts[i] = '0;
    base_history = '0;
    valid_run = '0;
    record_stop = 1'b0;
    kmer_len = 3'd7;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_contents();
    test_full_length_windows();
    test_length_change();
    test_random_stream(10, 75, 0);
    test_random_stream(75, 10, 4);
    test_random_stream(0, 0, 8);
    test_record_stop();

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d words: %0d k-mers counted, %0d counter reads", words_sent,
             kmers_counted, reads_sent);
    $display("k-mer lengths 0..7 incl. mid-stream changes, three stall profiles, record stop");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/khc_pkg.sv
hw/rtl/khc_front.sv
hw/rtl/khc_fifo.sv
hw/rtl/khc_back.sv
hw/rtl/kmer_histogram_counter_unit.sv
tb/testbench.sv
